// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module. They expand to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define LRUPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lru_page_replacement: assertion failed");
// Checked at every edge, reset included.
`define LRUPR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lru_page_replacement: reset assertion failed");
`else
`define LRUPR_ASSERT(label, prop)
`define LRUPR_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Types and fixed constants shared by the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int CFG_W        = 4;
  localparam int SLOT_OUT_W   = 3;
  localparam int FAULT_W      = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new page reference
    logic lookup;  // register tag match and victim choice
    logic commit;  // write the frame table and the result register
  } cmd_t;

endpackage

// File: rtl/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer for lookup and update, plus the result valid flag.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lrupr_pkg::cmd_t cmd
);

  lrupr_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrupr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    commit     = 1'b0;
    in_ready   = 1'b0;
    cmd.lookup = 1'b0;
    case (state_r)
      lrupr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lrupr_pkg::ST_LOOKUP;
        end
      end
      lrupr_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lrupr_pkg::ST_UPDATE;
      end
      lrupr_pkg::ST_UPDATE: begin
        // The update waits only while the result register still holds
        // an untaken result. A new reference can enter in the same cycle.
        commit   = !out_valid_r || out_ready;
        in_ready = commit;
        if (commit) begin
          state_nxt = in_valid ? lrupr_pkg::ST_LOOKUP : lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrupr_pkg::ST_IDLE;
      end
    endcase
    cmd.load   = in_valid && in_ready;
    cmd.commit = commit;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/lrupr_dpath.sv
// ----------------------------------------------------------------------------
// lrupr_dpath
// Frame table, tag compare, LRU victim tree, age update and result register.
// ----------------------------------------------------------------------------
module lrupr_dpath #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lrupr_pkg::cmd_t                  cmd,
  input  logic                             cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_data,
  input  logic [PAGE_BITS-1:0]             in_page_number,
  output logic                             out_page_fault,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic                             out_evicted_valid,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]    out_fault_total
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AGE_W  = SLOT_W;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;
  localparam int NP     = 1 << SLOT_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_FRAMES - 1);
  localparam logic [lrupr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

  // Configuration and state.
  logic [lrupr_pkg::CFG_W-1:0]   cfg_r;
  logic [PAGE_BITS-1:0]          page_in_r;
  logic [PAGE_BITS-1:0]          frame_page_r  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         frame_valid_r;
  logic [AGE_W-1:0]              frame_age_r   [MAX_FRAMES];
  logic [AGE_W-1:0]              frame_age_nxt [MAX_FRAMES];
  logic [CNT_W-1:0]              filled_r;
  logic [lrupr_pkg::FAULT_W-1:0] fault_r, fault_nxt;

  // Lookup results.
  logic                 hit_r, fill_r, ev_r, age_all_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [PAGE_BITS-1:0] evp_r;
  logic [AGE_W-1:0]     limit_r;

  // Combinational lookup.
  logic [CNT_W-1:0]      act;
  logic [CMP_W-1:0]      cfg_ext;
  logic [MAX_FRAMES-1:0] act_mask;
  logic [MAX_FRAMES-1:0] match;
  logic                  hit;
  logic [SLOT_W-1:0]     hit_idx;
  logic [SLOT_W-1:0]     slot_sel;
  logic                  fill_sel;
  logic                  ev_sel;
  logic [PAGE_BITS-1:0]  evp_sel;
  logic [SLOT_W-1:0]     victim;
  logic [SLOT_W+2:0]     slot_wide;

  // Victim tree: level 0 holds the leaves, level SLOT_W the winner.
  logic             t_cand [SLOT_W+1][NP];
  logic [AGE_W-1:0] t_age  [SLOT_W+1][NP];
  logic [SLOT_W-1:0] t_idx [SLOT_W+1][NP];
  logic             leaf_cand [NP];
  logic [AGE_W-1:0] leaf_age  [NP];

  // A count of zero acts as one; a count above the table size acts as the size.
  assign cfg_ext = CMP_W'(cfg_r);
  always_comb begin
    if (cfg_r == '0) begin
      act = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
      act = CNT_W'(MAX_FRAMES);
    end else begin
      act = CNT_W'(cfg_ext);
    end
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_frame
    assign act_mask[g] = CNT_W'(g) < act;
    assign match[g]    = act_mask[g] && frame_valid_r[g] &&
                         (frame_page_r[g] == page_in_r);
  end

  for (genvar g = 0; g < NP; g++) begin : g_leaf
    if (g < MAX_FRAMES) begin : g_real
      assign leaf_cand[g] = act_mask[g];
      assign leaf_age[g]  = frame_age_r[g];
    end else begin : g_pad
      assign leaf_cand[g] = 1'b0;
      assign leaf_age[g]  = '0;
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end
  assign hit = |match;

  // The right child replaces the left one only with a strictly larger age,
  // so ties go to the lowest slot.
  always_comb begin
    for (int l = 0; l <= SLOT_W; l++) begin
      for (int k = 0; k < NP; k++) begin
        t_cand[l][k] = 1'b0;
        t_age[l][k]  = '0;
        t_idx[l][k]  = '0;
      end
    end
    for (int k = 0; k < NP; k++) begin
      t_cand[0][k] = leaf_cand[k];
      t_age[0][k]  = leaf_age[k];
      t_idx[0][k]  = SLOT_W'(k);
    end
    for (int l = 0; l < SLOT_W; l++) begin
      for (int k = 0; k < (NP >> (l + 1)); k++) begin
        if (t_cand[l][2*k+1] &&
            (!t_cand[l][2*k] || (t_age[l][2*k+1] > t_age[l][2*k]))) begin
          t_cand[l+1][k] = 1'b1;
          t_age[l+1][k]  = t_age[l][2*k+1];
          t_idx[l+1][k]  = t_idx[l][2*k+1];
        end else begin
          t_cand[l+1][k] = t_cand[l][2*k];
          t_age[l+1][k]  = t_age[l][2*k];
          t_idx[l+1][k]  = t_idx[l][2*k];
        end
      end
    end
    victim = t_idx[SLOT_W][0];
  end

  always_comb begin
    fill_sel = 1'b0;
    ev_sel   = 1'b0;
    evp_sel  = '0;
    if (hit) begin
      slot_sel = hit_idx;
    end else if (filled_r < act) begin
      slot_sel = SLOT_W'(filled_r);
      fill_sel = 1'b1;
    end else begin
      slot_sel = victim;
      ev_sel   = frame_valid_r[victim];
      evp_sel  = frame_valid_r[victim] ? frame_page_r[victim] : '0;
    end
  end

  // Age update: the used slot becomes the most recent. On a hit only the
  // frames younger than it age; on a miss every active valid frame ages.
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      frame_age_nxt[i] = frame_age_r[i];
      if (SLOT_W'(i) == slot_r) begin
        frame_age_nxt[i] = '0;
      end else if (act_mask[i] && frame_valid_r[i] && (frame_age_r[i] != AGE_MAX) &&
                   (age_all_r || (frame_age_r[i] < limit_r))) begin
        frame_age_nxt[i] = frame_age_r[i] + AGE_W'(1);
      end
    end
    fault_nxt = (fault_r == FAULT_MAX) ? fault_r : fault_r + lrupr_pkg::FAULT_W'(1);
  end

  assign slot_wide = (SLOT_W + 3)'(slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= lrupr_pkg::CFG_RESET;
      frame_valid_r <= '0;
      filled_r      <= '0;
      fault_r       <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_age_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.commit) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
          frame_age_r[i] <= frame_age_nxt[i];
        end
        if (!hit_r) begin
          frame_valid_r[slot_r] <= 1'b1;
          fault_r               <= fault_nxt;
          if (fill_r) begin
            filled_r <= filled_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_in_r <= in_page_number;
    end
    if (cmd.lookup) begin
      hit_r     <= hit;
      slot_r    <= slot_sel;
      fill_r    <= fill_sel;
      ev_r      <= ev_sel;
      evp_r     <= evp_sel;
      age_all_r <= !hit;
      limit_r   <= frame_age_r[hit_idx];
    end
    if (cmd.commit) begin
      if (!hit_r) begin
        frame_page_r[slot_r] <= page_in_r;
      end
      out_page_fault    <= !hit_r;
      out_slot_index    <= slot_wide[lrupr_pkg::SLOT_OUT_W-1:0];
      out_evicted_valid <= ev_r;
      out_evicted_page  <= evp_r;
      out_fault_total   <= hit_r ? fault_r : fault_nxt;
    end
  end

endmodule

// File: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative page frame table with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage: each transfer on the in_ channel is one page reference. The block
// answers each with exactly one transfer on the out_ channel: the hit or fault
// flag, the slot hit or written, the evicted page (zero when none), and the
// saturating fault count including this reference.
// The cfg_ channel writes frames_in_use (4 bits, 3 after reset); write it only
// while no reference is in flight. Zero acts as one frame, values above
// MAX_FRAMES act as MAX_FRAMES.
// A reference's tag compare and victim search are registered in the lookup
// state; its age and frame writes and its result follow in the update state.
// A new reference is taken while idle or in the update state, never in lookup.
// A result waiting in the output register does not block the next reference's
// lookup; only its table update waits until the result is taken.
// Reset empties the frame table, clears ages, fill and fault counts, and drops
// any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PAGE_BITS-1:0]             in_page_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_page_fault,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic                             out_evicted_valid,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]    out_fault_total
);

  lrupr_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lrupr_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_page_number    (in_page_number),
    .out_page_fault    (out_page_fault),
    .out_slot_index    (out_slot_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  // A new reference always passes through lookup before the next can enter.
  `LRUPR_ASSERT(a_accept_then_busy, (in_valid && in_ready) |=> !in_ready)
  // A hit never evicts anything.
  `LRUPR_ASSERT(a_hit_no_evict, (out_valid && !out_page_fault) |-> !out_evicted_valid)
  // Without an eviction the evicted page reads as zero.
  `LRUPR_ASSERT(a_no_evict_zero, (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
  // Reset drops any pending result.
  `LRUPR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

// File: verif/lru_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_checker
// Watches the configuration, reference and result channels of the LRU page
// replacement block. It keeps its own frame table with per-frame ages,
// computes the expected result for every accepted page reference, and
// compares each accepted result against the oldest expected one.
// ----------------------------------------------------------------------------
module lru_frame_checker #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [PAGE_BITS-1:0]             in_page_number,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_page_fault,
  input  logic [lrupr_pkg::SLOT_OUT_W-1:0] out_slot_index,
  input  logic                             out_evicted_valid,
  input  logic [PAGE_BITS-1:0]             out_evicted_page,
  input  logic [lrupr_pkg::FAULT_W-1:0]    out_fault_total,
  output int                               results_owed,
  output int                               mismatch_count
);

  typedef struct packed {
    logic                             fault;
    logic [lrupr_pkg::SLOT_OUT_W-1:0] slot;
    logic                             ev_valid;
    logic [PAGE_BITS-1:0]             ev_page;
    logic [lrupr_pkg::FAULT_W-1:0]    total;
  } page_result_t;

  logic [PAGE_BITS-1:0]          frame_page [MAX_FRAMES];
  bit                            frame_valid [MAX_FRAMES];
  int                            frame_age [MAX_FRAMES];
  int                            filled;
  logic [lrupr_pkg::FAULT_W-1:0] fault_count;
  logic [lrupr_pkg::CFG_W-1:0]   frames_cfg;
  page_result_t                  awaited_results[$];
  int                            errs = 0;

  // Applies one reference to the local frame table and returns its result.
  function automatic page_result_t replay_reference(input logic [PAGE_BITS-1:0] page);
    page_result_t r;
    int act;
    int slot;
    int limit;
    int i;
    bit hit;
    act = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg));
    hit = 1'b0;
    slot = 0;
    r = '0;
    for (i = 0; i < act; i++) begin
      if (!hit && frame_valid[i] && frame_page[i] == page) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      limit = frame_age[slot];
    end else begin
      limit = 256;
      if (filled < act) begin
        slot = filled;
        filled++;
      end else begin
        // Oldest frame wins; ties go to the lowest slot.
        for (i = 1; i < act; i++) begin
          if (frame_age[i] > frame_age[slot]) slot = i;
        end
        r.ev_valid = frame_valid[slot];
        if (frame_valid[slot]) r.ev_page = frame_page[slot];
      end
      frame_page[slot] = page;
      frame_valid[slot] = 1'b1;
      if (fault_count != '1) fault_count++;
    end
    for (i = 0; i < act; i++) begin
      if (i != slot && frame_valid[i] && frame_age[i] < limit &&
          frame_age[i] < MAX_FRAMES - 1)
        frame_age[i]++;
    end
    frame_age[slot] = 0;
    r.fault = !hit;
    r.slot = lrupr_pkg::SLOT_OUT_W'(slot);
    r.total = fault_count;
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (!rst_n) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        frame_valid[k] = 1'b0;
        frame_age[k] = 0;
      end
      filled = 0;
      fault_count = '0;
      frames_cfg = lrupr_pkg::CFG_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) frames_cfg = cfg_data;
      // Results are checked before new references are queued, so a result
      // can never be matched against an expectation from the same edge.
      if (out_valid && out_ready) begin
        got = {out_page_fault, out_slot_index, out_evicted_valid, out_evicted_page,
               out_fault_total};
        if (awaited_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("lru_frame_checker: %0t: result transfer with none expected", $time);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display({"lru_frame_checker: %0t: expected fault=%0d slot=%0d ev=%0d ",
                        "evpage=%h total=%0d, got fault=%0d slot=%0d ev=%0d ",
                        "evpage=%h total=%0d"}, $time,
                       want.fault, want.slot, want.ev_valid, want.ev_page, want.total,
                       got.fault, got.slot, got.ev_valid, got.ev_page, got.total);
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(replay_reference(in_page_number));
    end
    results_owed <= awaited_results.size();
    mismatch_count <= errs;
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LRU page replacement block. A directed run of
// fills, hits, evictions and active-count changes is followed by random
// phases, each with its own frame count and working set of pages, under
// bursty input traffic and a varying output stall pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 20;
  localparam int PHASES     = 14;
  localparam int PHASE_REFS = 74;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lrupr_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [PAGE_BITS-1:0]             in_page_number = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             out_page_fault;
  logic [lrupr_pkg::SLOT_OUT_W-1:0] out_slot_index;
  logic                             out_evicted_valid;
  logic [PAGE_BITS-1:0]             out_evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]    out_fault_total;
  int                               results_owed;
  int                               mismatch_count;

  logic [lrupr_pkg::CFG_W-1:0] frame_plan [PHASES] =
    '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8, 4'd4, 4'd3, 4'd7, 4'd6, 4'd12, 4'd1, 4'd8};
  logic [PAGE_BITS-1:0] page_pool [16];
  logic [PAGE_BITS-1:0] opening_refs [14] =
    '{20'h00000, 20'hFFFFF, 20'h00000, 20'h12345, 20'hABCDE, 20'hFFFFF, 20'h00000,
      20'h00000, 20'h12345, 20'h80000, 20'h7FFFF, 20'h55555, 20'hAAAAA, 20'h55555};
  int burst_left = 0;
  bit gapless = 1'b0;
  int cyc = 0;

  lru_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_fault   (out_page_fault),
    .out_slot_index   (out_slot_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total)
  );

  lru_frame_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_fault   (out_page_fault),
    .out_slot_index   (out_slot_index),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total),
    .results_owed     (results_owed),
    .mismatch_count   (mismatch_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Receiver stall pattern: always ready, coin flips, a fixed duty cycle, and
  // long stalls, taken in turn.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case ((cyc / 300) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cyc % 7) < 4;
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Called right after a rising edge; returns right after the edge at which
  // the reference transfer took place, with in_valid still high.
  task automatic send_page(input logic [PAGE_BITS-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_page_number <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // The register may only change once every result is back.
  task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ws;
    logic [PAGE_BITS-1:0] p;
    for (int k = 0; k < 16; k++)
      page_pool[k] = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
    page_pool[0] = '0;
    page_pool[15] = '1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fills, hits and evictions with the reset frame count, then a
    // shrink that strands a frame and a grow that brings it back.
    for (int k = 0; k < 14; k++) send_page(opening_refs[k]);
    write_frames(4'd2);
    send_page(20'h55555);
    send_page(20'hAAAAA);
    send_page(20'h00000);
    send_page(20'hAAAAA);
    write_frames(4'd4);
    send_page(20'h55555);
    send_page(20'h00000);
    send_page(20'h31415);
    send_page(20'h27182);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_frames(frame_plan[ph]);
      gapless = (ph % 4 == 3);
      burst_left = 0;
      for (int k = 0; k < 3; k++)
        page_pool[4'($urandom_range(1, 14))] =
          PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
      ws = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_REFS; n++) begin
        if ($urandom_range(0, 6) == 0) p = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
        else p = page_pool[4'($urandom_range(0, ws - 1))];
        send_page(p);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lrupr_pkg.sv
rtl/lrupr_ctrl.sv
rtl/lrupr_dpath.sv
rtl/lru_page_replacement.sv
verif/lru_frame_checker.sv
verif/tb_top.sv
